[design/itoa_pkg.sv]
`timescale 1ns / 1ps

package itoa_pkg;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } back_state_t;

endpackage

[design/itoa_front.sv]
`timescale 1ns / 1ps

module itoa_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic [DATA_WIDTH:0]          q_data
);

  logic                  neg;
  logic [DATA_WIDTH-1:0] mag;

  // magnitude of the most negative value wraps to 2^(W-1), exact as unsigned
  assign neg      = in_value[DATA_WIDTH-1];
  assign mag      = neg ? (~in_value + 1'b1) : in_value;
  assign q_data   = {neg, mag};
  assign q_valid  = in_valid;
  assign in_ready = q_ready;

endmodule

[design/itoa_queue.sv]
`timescale 1ns / 1ps

module itoa_queue #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[design/itoa_back.sv]
`timescale 1ns / 1ps

module itoa_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [DATA_WIDTH:0]   q_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_character,
  output logic                  out_last
);

  localparam int NDIG = (DATA_WIDTH * 302) / 1000 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int CW   = $clog2(DATA_WIDTH);
  localparam int IW   = $clog2(NDIG);

  itoa_pkg::back_state_t state_r, state_nxt;
  logic [DATA_WIDTH-1:0] mag_r, mag_nxt;
  logic [BW-1:0]         bcd_r, bcd_nxt, bcd_adj;
  logic                  neg_r, neg_nxt;
  logic                  sign_pend_r, sign_pend_nxt;
  logic                  started_r, started_nxt;
  logic [CW-1:0]         shift_cnt_r, shift_cnt_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_free;
  logic [3:0]            top_digit;
  logic                  show;

  assign q_ready       = (state_r == itoa_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_free      = !out_valid_r || out_ready;
  assign top_digit     = bcd_r[BW-1 -: 4];
  assign show          = started_r || (top_digit != 4'd0) || (idx_r == '0);

  // add-3 on every BCD digit of 5 or more before each shift
  always_comb begin
    bcd_adj = bcd_r;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    started_nxt   = started_r;
    shift_cnt_nxt = shift_cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (q_valid) begin
          neg_nxt       = q_data[DATA_WIDTH];
          mag_nxt       = q_data[DATA_WIDTH-1:0];
          bcd_nxt       = '0;
          shift_cnt_nxt = '0;
          state_nxt     = itoa_pkg::ST_CONV;
        end
      end
      itoa_pkg::ST_CONV: begin
        {bcd_nxt, mag_nxt} = {bcd_adj[BW-2:0], mag_r, 1'b0};
        shift_cnt_nxt      = shift_cnt_r + 1'b1;
        if (shift_cnt_r == CW'(DATA_WIDTH - 1)) begin
          sign_pend_nxt = neg_r;
          started_nxt   = 1'b0;
          idx_nxt       = IW'(NDIG - 1);
          state_nxt     = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (sign_pend_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = itoa_pkg::CHAR_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end
        end else if (!show) begin
          bcd_nxt = {bcd_r[BW-5:0], 4'd0};
          idx_nxt = idx_r - 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itoa_pkg::CHAR_ZERO + {4'd0, top_digit};
          out_last_nxt  = (idx_r == '0);
          bcd_nxt       = {bcd_r[BW-5:0], 4'd0};
          idx_nxt       = idx_r - 1'b1;
          started_nxt   = 1'b1;
          if (idx_r == '0) begin
            state_nxt = itoa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
      started_r   <= 1'b0;
      shift_cnt_r <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
      started_r   <= started_nxt;
      shift_cnt_r <= shift_cnt_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

[design/signed_int_to_decimal_ascii_core.sv]
`timescale 1ns / 1ps

// Converts a signed DATA_WIDTH-bit integer to its decimal ASCII text, one
// character per output transaction, most significant digit first, with a
// leading '-' for negative values and out_last on the final digit. Values
// are classified into sign and magnitude and held in a two-entry queue, so
// up to two further values are taken while one is being converted. The
// converter is a double-dabble shifter that takes in the magnitude bit by
// bit, then walks the BCD digit positions from the top, emitting the sign
// first and skipping leading zeros; emission waits while out_ready is low.
module signed_int_to_decimal_ascii_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_character,
  output logic                         out_last
);

  logic                f_valid, f_ready;
  logic [DATA_WIDTH:0] f_data;
  logic                b_valid, b_ready;
  logic [DATA_WIDTH:0] b_data;

  itoa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  itoa_queue #(.WIDTH(DATA_WIDTH + 1)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  itoa_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (b_valid),
    .q_ready       (b_ready),
    .q_data        (b_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

[design/itoa_checker.sv]
`timescale 1ns / 1ps

module itoa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_character,
  input logic       out_last
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("stalled output transaction changed");

  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == itoa_pkg::CHAR_MINUS) ||
                  ((out_character >= itoa_pkg::CHAR_ZERO) &&
                   (out_character <= itoa_pkg::CHAR_NINE)))
    else $error("character outside sign and digits");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == itoa_pkg::CHAR_MINUS) |-> !out_last)
    else $error("sign flagged as last");

endmodule

bind signed_int_to_decimal_ascii_core itoa_checker u_itoa_checker (.*);
